/* rtl/core/mms_pkg.sv */
// Package of types and codes shared by the mobility mode supervisor files.
`default_nettype none

package mms_pkg;

   typedef enum logic [2:0] {
      MODE_FREE_ROLL  = 3'd0,
      MODE_ASSISTED   = 3'd1,
      MODE_GET_GOAL   = 3'd2,
      MODE_NAVIGATING = 3'd3,
      MODE_AT_GOAL    = 3'd4
   } mode_type;

   localparam logic [1:0] PHONE_NONE    = 2'd0;
   localparam logic [1:0] PHONE_CANCEL  = 2'd1;
   localparam logic [1:0] PHONE_START   = 2'd2;
   localparam logic [1:0] PHONE_UNKNOWN = 2'd3;

   localparam logic [1:0] SCREEN_NONE    = 2'd0;
   localparam logic [1:0] SCREEN_ASSIST  = 2'd1;
   localparam logic [1:0] SCREEN_FREE    = 2'd2;
   localparam logic [1:0] SCREEN_UNKNOWN = 2'd3;

   localparam logic [1:0] NAV_ACTIVE    = 2'd0;
   localparam logic [1:0] NAV_SUCCEEDED = 2'd1;
   localparam logic [1:0] NAV_FAILED    = 2'd2;
   localparam logic [1:0] NAV_OTHER     = 2'd3;

   typedef struct packed {
      logic [1:0] phone_event;
      logic [1:0] screen_event;
      logic       slider_valid;
      logic       slider_level;
      logic       goal_arrived;
      logic [1:0] nav_status;
   } req_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       free_roll_ok;
      logic       use_slider_velocity;
      logic       send_goal;
      logic       cancel_goal;
   } rsp_type;

   typedef struct packed {
      mode_type mode;
      logic     phone_pending;
      logic     phone_is_start;
      logic     screen_pending;
      logic     screen_is_assist;
      logic     slider_changed;
      logic     goal_pending;
      logic     free_roll_held;
      logic     slider_use_held;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:             MODE_ASSISTED,
      phone_pending:    1'b0,
      phone_is_start:   1'b0,
      screen_pending:   1'b0,
      screen_is_assist: 1'b0,
      slider_changed:   1'b0,
      goal_pending:     1'b0,
      free_roll_held:   1'b1,
      slider_use_held:  1'b1
   };

endpackage

`default_nettype wire

/* rtl/core/mms_chan_if.sv */
// Valid/ready channel interfaces for the request and result streams.
`default_nettype none

interface mms_req_if;
   logic             valid;
   logic             ready;
   mms_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mms_rsp_if;
   logic             valid;
   logic             ready;
   mms_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/mms_step.sv */
// Next-state and result logic for one control period of the supervisor.
`default_nettype none

module mms_step (
   input  mms_pkg::state_type state_cur,
   input  mms_pkg::req_type   request,
   output mms_pkg::state_type state_nxt,
   output mms_pkg::rsp_type   result
);

   mms_pkg::state_type merged;
   logic               send;
   logic               cancel;
   logic               nav;

   always_comb begin
      merged = state_cur;
      if (request.phone_event != mms_pkg::PHONE_NONE) begin
         if (request.phone_event == mms_pkg::PHONE_CANCEL) begin
            merged.phone_is_start = 1'b0;
         end else if (request.phone_event == mms_pkg::PHONE_START) begin
            merged.phone_is_start = 1'b1;
         end
         merged.phone_pending = 1'b1;
      end
      if (request.screen_event != mms_pkg::SCREEN_NONE) begin
         if (request.screen_event == mms_pkg::SCREEN_ASSIST) begin
            merged.screen_is_assist = 1'b1;
         end else if (request.screen_event == mms_pkg::SCREEN_FREE) begin
            merged.screen_is_assist = 1'b0;
         end
         merged.screen_pending = 1'b1;
      end
      if (request.slider_valid) begin
         merged.slider_changed = request.slider_level;
      end
      if (request.goal_arrived) begin
         merged.goal_pending = 1'b1;
      end
   end

   always_comb begin
      state_nxt = merged;
      send      = 1'b0;
      cancel    = 1'b0;
      nav       = (state_cur.mode == mms_pkg::MODE_NAVIGATING);
      unique case (state_cur.mode)
         mms_pkg::MODE_FREE_ROLL, mms_pkg::MODE_ASSISTED: begin
            if (merged.screen_pending) begin
               if (state_cur.mode == mms_pkg::MODE_FREE_ROLL && merged.screen_is_assist) begin
                  state_nxt.mode = mms_pkg::MODE_ASSISTED;
               end
               if (state_cur.mode == mms_pkg::MODE_ASSISTED && !merged.screen_is_assist) begin
                  state_nxt.mode = mms_pkg::MODE_FREE_ROLL;
               end
               state_nxt.screen_pending = 1'b0;
            end else if (merged.phone_pending) begin
               if (merged.phone_is_start) begin
                  state_nxt.mode = mms_pkg::MODE_GET_GOAL;
               end
               state_nxt.phone_pending = 1'b0;
            end
            state_nxt.free_roll_held  = (state_cur.mode == mms_pkg::MODE_FREE_ROLL);
            state_nxt.slider_use_held = (state_cur.mode == mms_pkg::MODE_ASSISTED);
         end
         mms_pkg::MODE_GET_GOAL, mms_pkg::MODE_NAVIGATING: begin
            priority if (merged.slider_changed) begin
               state_nxt.mode           = mms_pkg::MODE_FREE_ROLL;
               cancel                   = nav;
               state_nxt.slider_changed = 1'b0;
            end else if (merged.screen_pending) begin
               state_nxt.mode           = mms_pkg::MODE_FREE_ROLL;
               cancel                   = nav;
               state_nxt.screen_pending = 1'b0;
            end else if (merged.phone_pending) begin
               if (!merged.phone_is_start) begin
                  state_nxt.mode = mms_pkg::MODE_FREE_ROLL;
               end
               cancel                  = nav;
               state_nxt.phone_pending = 1'b0;
            end else if (!nav) begin
               if (merged.goal_pending) begin
                  send                   = 1'b1;
                  state_nxt.mode         = mms_pkg::MODE_NAVIGATING;
                  state_nxt.goal_pending = 1'b0;
               end
            end else if (request.nav_status == mms_pkg::NAV_ACTIVE) begin
               state_nxt.mode = mms_pkg::MODE_NAVIGATING;
            end else if (request.nav_status == mms_pkg::NAV_SUCCEEDED) begin
               state_nxt.mode = mms_pkg::MODE_AT_GOAL;
            end else begin
               cancel         = 1'b1;
               state_nxt.mode = mms_pkg::MODE_FREE_ROLL;
            end
            state_nxt.free_roll_held  = 1'b0;
            state_nxt.slider_use_held = 1'b0;
         end
         default: begin
            state_nxt.mode = mms_pkg::MODE_FREE_ROLL;
         end
      endcase

      result.mode                = state_cur.mode;
      result.free_roll_ok        = state_nxt.free_roll_held;
      result.use_slider_velocity = state_nxt.slider_use_held;
      result.send_goal           = send;
      result.cancel_goal         = cancel;
   end

endmodule

`default_nettype wire

/* rtl/core/mobility_mode_supervisor.sv */
// Top level of the mobility mode supervisor: request register, step logic, result register.
// Each request is one control period carrying the phone, screen, slider, goal and
// navigation-status events latched since the previous period. Each request yields
// exactly one result: the mode evaluated, the free-roll and slider-velocity
// permissions, and the send-goal and cancel-goal pulses.
// Both channels use valid/ready; a request or result moves when both are high.
// A request is held in the input register, evaluated against the mode state by the
// step logic, and written to the result register when it advances, so the result
// becomes valid as the request leaves the input register and stays until taken.
// Throughput is one request per cycle unless the receiver stalls, set by the combinational
// step logic that updates the mode state as each request passes into the result register.
// When the receiver stalls, the result register holds its value, the input
// register holds the next request, and ready drops once both are full.
// Synchronous reset empties both registers and returns the mode to assisted with
// no events pending and both permissions held high.
`default_nettype none

module mobility_mode_supervisor (
   input  wire        clock,
   input  wire        reset,
   mms_req_if.sink    req_ch,
   mms_rsp_if.source  rsp_ch
);

   logic               in_valid_ff;
   logic               in_valid_in;
   mms_pkg::req_type   in_data_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   mms_pkg::rsp_type   out_data_ff;
   mms_pkg::state_type state_ff;
   mms_pkg::state_type state_in;
   mms_pkg::rsp_type   step_result;
   logic               advance;
   logic               req_take;

   mms_step u_step (
      .state_cur (state_ff),
      .request   (in_data_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= mms_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_ch.payload;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   // A goal is only sent from get goal and only cancelled while navigating.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.send_goal |->
         out_data_ff.mode == mms_pkg::MODE_GET_GOAL)
      else $error("send_goal outside get goal mode");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.cancel_goal |->
         out_data_ff.mode == mms_pkg::MODE_NAVIGATING)
      else $error("cancel_goal outside navigating mode");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_data_ff.send_goal && out_data_ff.cancel_goal))
      else $error("send_goal and cancel_goal raised together");

   // At goal always falls back to free roll on the next request.
   assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.mode == mms_pkg::MODE_AT_GOAL |=>
         state_ff.mode == mms_pkg::MODE_FREE_ROLL)
      else $error("at goal did not return to free roll");

   // The mode state only changes when a request passes into the result register.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("mode state changed without a request");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the mobility mode supervisor with driver, monitor and predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PERIODS = 1430;
   localparam int QUIET_TAIL = 150;
   localparam int LONG_HOLD_AFTER = 400;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mms_req_if req_if ();
   mms_rsp_if rsp_if ();

   mobility_mode_supervisor i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   mms_pkg::req_type   pending_periods[$];
   bit                 pending_pause[$];
   mms_pkg::rsp_type   awaited_outputs[$];
   mms_pkg::state_type sup_state = mms_pkg::STATE_RESET;

   int   mismatches = 0;
   int   cycle_count = 0;
   int   outputs_seen = 0;
   logic req_taken = 1'b0;

   int idle_levels[4] = '{0, 10, 30, 60};
   int src_idle_pct = 0;
   int sink_idle_pct = 0;
   int gap_left = 0;
   int stall_left = 0;
   bit long_hold_done = 1'b0;

   always #6 clock = ~clock;

   task automatic advance_supervisor(input mms_pkg::req_type rq, output mms_pkg::rsp_type rs);
      mms_pkg::mode_type cur;
      mms_pkg::mode_type nxt;
      logic              on_nav;
      begin
         cur = sup_state.mode;
         nxt = cur;
         rs = '0;
         if (rq.phone_event != mms_pkg::PHONE_NONE) begin
            if (rq.phone_event == mms_pkg::PHONE_CANCEL) sup_state.phone_is_start = 1'b0;
            else if (rq.phone_event == mms_pkg::PHONE_START) sup_state.phone_is_start = 1'b1;
            sup_state.phone_pending = 1'b1;
         end
         if (rq.screen_event != mms_pkg::SCREEN_NONE) begin
            if (rq.screen_event == mms_pkg::SCREEN_ASSIST) sup_state.screen_is_assist = 1'b1;
            else if (rq.screen_event == mms_pkg::SCREEN_FREE) sup_state.screen_is_assist = 1'b0;
            sup_state.screen_pending = 1'b1;
         end
         if (rq.slider_valid) sup_state.slider_changed = rq.slider_level;
         if (rq.goal_arrived) sup_state.goal_pending = 1'b1;

         unique case (cur)
            mms_pkg::MODE_FREE_ROLL, mms_pkg::MODE_ASSISTED: begin
               if (sup_state.screen_pending) begin
                  if (cur == mms_pkg::MODE_FREE_ROLL && sup_state.screen_is_assist) begin
                     nxt = mms_pkg::MODE_ASSISTED;
                  end
                  if (cur == mms_pkg::MODE_ASSISTED && !sup_state.screen_is_assist) begin
                     nxt = mms_pkg::MODE_FREE_ROLL;
                  end
                  sup_state.screen_pending = 1'b0;
               end else if (sup_state.phone_pending) begin
                  if (sup_state.phone_is_start) nxt = mms_pkg::MODE_GET_GOAL;
                  sup_state.phone_pending = 1'b0;
               end
               sup_state.free_roll_held = (cur == mms_pkg::MODE_FREE_ROLL);
               sup_state.slider_use_held = (cur == mms_pkg::MODE_ASSISTED);
            end
            mms_pkg::MODE_GET_GOAL, mms_pkg::MODE_NAVIGATING: begin
               on_nav = (cur == mms_pkg::MODE_NAVIGATING);
               if (sup_state.slider_changed) begin
                  nxt = mms_pkg::MODE_FREE_ROLL;
                  rs.cancel_goal = on_nav;
                  sup_state.slider_changed = 1'b0;
               end else if (sup_state.screen_pending) begin
                  nxt = mms_pkg::MODE_FREE_ROLL;
                  rs.cancel_goal = on_nav;
                  sup_state.screen_pending = 1'b0;
               end else if (sup_state.phone_pending) begin
                  if (!sup_state.phone_is_start) nxt = mms_pkg::MODE_FREE_ROLL;
                  rs.cancel_goal = on_nav;
                  sup_state.phone_pending = 1'b0;
               end else if (!on_nav) begin
                  if (sup_state.goal_pending) begin
                     rs.send_goal = 1'b1;
                     nxt = mms_pkg::MODE_NAVIGATING;
                     sup_state.goal_pending = 1'b0;
                  end
               end else if (rq.nav_status == mms_pkg::NAV_ACTIVE) begin
                  nxt = mms_pkg::MODE_NAVIGATING;
               end else if (rq.nav_status == mms_pkg::NAV_SUCCEEDED) begin
                  nxt = mms_pkg::MODE_AT_GOAL;
               end else begin
                  rs.cancel_goal = 1'b1;
                  nxt = mms_pkg::MODE_FREE_ROLL;
               end
               sup_state.free_roll_held = 1'b0;
               sup_state.slider_use_held = 1'b0;
            end
            default: begin
               nxt = mms_pkg::MODE_FREE_ROLL;
            end
         endcase

         sup_state.mode = nxt;
         rs.mode = cur;
         rs.free_roll_ok = sup_state.free_roll_held;
         rs.use_slider_velocity = sup_state.slider_use_held;
      end
   endtask

   function automatic int check_field(string name, logic [2:0] want, logic [2:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   function automatic mms_pkg::req_type period(logic [1:0] ph, logic [1:0] sc, logic sv,
                                               logic sm, logic ga, logic [1:0] ns);
      mms_pkg::req_type rq;
      rq.phone_event = ph;
      rq.screen_event = sc;
      rq.slider_valid = sv;
      rq.slider_level = sm;
      rq.goal_arrived = ga;
      rq.nav_status = ns;
      return rq;
   endfunction

   task automatic queue_period(input mms_pkg::req_type rq, input bit pause);
      pending_periods.push_back(rq);
      pending_pause.push_back(pause);
   endtask

   // Request driver.
   always @(negedge clock) begin
      if (!reset) begin
         if (cycle_count % 128 == 0) src_idle_pct = idle_levels[$urandom_range(0, 3)];
         if (req_if.valid && !req_taken) begin
            req_if.valid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_if.valid <= 1'b0;
         end else if (pending_periods.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (pending_pause[0] && awaited_outputs.size() != 0) begin
            req_if.valid <= 1'b0;
         end else if (pending_periods.size() > QUIET_TAIL &&
                      $urandom_range(0, 99) < src_idle_pct) begin
            gap_left = $urandom_range(1, 16) - 1;
            req_if.valid <= 1'b0;
         end else begin
            req_if.payload <= pending_periods.pop_front();
            void'(pending_pause.pop_front());
            req_if.valid <= 1'b1;
         end
      end
   end

   // Result sink with random stalls and one long hold-off.
   always @(negedge clock) begin
      if (!reset) begin
         if (cycle_count % 128 == 0) sink_idle_pct = idle_levels[$urandom_range(0, 3)];
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else if (!long_hold_done && outputs_seen >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else if (pending_periods.size() > QUIET_TAIL &&
                      $urandom_range(0, 99) < sink_idle_pct) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Monitor: checks results against predictions, then predicts accepted requests.
   always @(posedge clock) begin
      mms_pkg::rsp_type predicted;
      mms_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (reset) begin
         sup_state = mms_pkg::STATE_RESET;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            outputs_seen <= outputs_seen + 1;
            if (awaited_outputs.size() == 0) begin
               $error("unexpected output: mode %0d", rsp_if.payload.mode);
               mismatches <= mismatches + 1;
            end else begin
               want = awaited_outputs.pop_front();
               mismatches <= mismatches
                  + check_field("mode", want.mode, rsp_if.payload.mode)
                  + check_field("free_roll_ok", 3'(want.free_roll_ok),
                                3'(rsp_if.payload.free_roll_ok))
                  + check_field("use_slider_velocity", 3'(want.use_slider_velocity),
                                3'(rsp_if.payload.use_slider_velocity))
                  + check_field("send_goal", 3'(want.send_goal),
                                3'(rsp_if.payload.send_goal))
                  + check_field("cancel_goal", 3'(want.cancel_goal),
                                3'(rsp_if.payload.cancel_goal));
            end
         end
         if (req_if.valid && req_if.ready) begin
            advance_supervisor(req_if.payload, predicted);
            awaited_outputs.push_back(predicted);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      mms_pkg::req_type rq;
      int               r;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;

      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_START, mms_pkg::SCREEN_FREE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b1,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_UNKNOWN, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_SUCCEEDED), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_ASSIST, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_UNKNOWN, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_START, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_NONE, 1'b1, 1'b1, 1'b1,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_START, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_FAILED), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_NONE, 1'b1, 1'b1, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_START, mms_pkg::SCREEN_NONE, 1'b1, 1'b0, 1'b1,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_OTHER), 1'b0);
      queue_period(period(mms_pkg::PHONE_START, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b1,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_NONE, mms_pkg::SCREEN_UNKNOWN, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_START, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b1,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_CANCEL, mms_pkg::SCREEN_NONE, 1'b0, 1'b0, 1'b0,
                          mms_pkg::NAV_ACTIVE), 1'b0);
      queue_period(period(mms_pkg::PHONE_UNKNOWN, mms_pkg::SCREEN_UNKNOWN, 1'b1, 1'b1, 1'b1,
                          mms_pkg::NAV_OTHER), 1'b0);

      for (int i = 0; i < RANDOM_PERIODS; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            rq = mms_pkg::req_type'($urandom);
         end else begin
            r = $urandom_range(0, 99);
            rq.phone_event = (r < 65) ? mms_pkg::PHONE_NONE : (r < 85) ? mms_pkg::PHONE_START :
                             (r < 95) ? mms_pkg::PHONE_CANCEL : mms_pkg::PHONE_UNKNOWN;
            r = $urandom_range(0, 99);
            rq.screen_event = (r < 88) ? mms_pkg::SCREEN_NONE :
                              (r < 93) ? mms_pkg::SCREEN_ASSIST :
                              (r < 97) ? mms_pkg::SCREEN_FREE : mms_pkg::SCREEN_UNKNOWN;
            rq.slider_valid = ($urandom_range(0, 99) < 8);
            rq.slider_level = 1'($urandom_range(0, 1));
            rq.goal_arrived = ($urandom_range(0, 99) < 30);
            r = $urandom_range(0, 99);
            rq.nav_status = (r < 75) ? mms_pkg::NAV_ACTIVE : (r < 88) ? mms_pkg::NAV_SUCCEEDED :
                            (r < 96) ? mms_pkg::NAV_FAILED : mms_pkg::NAV_OTHER;
         end
         queue_period(rq, (i == 0) || (i == 700));
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_periods.size() != 0 || req_if.valid || awaited_outputs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && awaited_outputs.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
